// ===== design/nlej_pkg.sv =====
// ----------------------------------------------------------------------------
// nlej_pkg
// Shared widths, command and status codes of the nested loop equi-join engine.
// ----------------------------------------------------------------------------
package nlej_pkg;

	localparam int NLEJ_DEPTH = 64;
	localparam int ID_W       = 31;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 32;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_MATCH   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	typedef logic [ID_W-1:0]         id_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;

endpackage

// ===== design/nlej_req_if.sv =====
// ----------------------------------------------------------------------------
// nlej_req_if
// Command channel: clear, load of a right tuple, probe with a left tuple.
// ----------------------------------------------------------------------------
interface nlej_req_if import nlej_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	id_t              tuple_id;
	val_t             tuple_val;

	modport source (output valid, output cmd, output tuple_id, output tuple_val, input ready);
	modport sink (input valid, input cmd, input tuple_id, input tuple_val, output ready);
endinterface

// ===== design/nlej_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nlej_rsp_if
// Result channel: match, no-match and refused-load beats.
// ----------------------------------------------------------------------------
interface nlej_rsp_if import nlej_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	id_t               left_id;
	id_t               right_id;
	val_t              match_val;
	cnt_t              match_total;
	logic              last;

	modport source (output valid, output status, output left_id, output right_id,
		output match_val, output match_total, output last, input ready);
	modport sink (input valid, input status, input left_id, input right_id,
		input match_val, input match_total, input last, output ready);
endinterface

// ===== design/nested_loop_equi_join.sv =====
// ----------------------------------------------------------------------------
// nested_loop_equi_join
// Right-hand tuples are stored in a table memory; each left-hand probe scans
// the table in load order and returns one beat per equal key.
// Channels: req carries cmd, tuple_id and tuple_val; rsp carries status,
// left_id, right_id, match_val, match_total and last.
// A clear or a load with room returns nothing. A load into a full table
// returns one refused beat, registered in the cycle after acceptance.
// A probe reads one table entry per cycle, unless rsp stalls, from a single
// synchronous memory port and scans every stored tuple (at most TABLE_DEPTH);
// an empty table is not read at all. Each match is held
// in a pending register until the next match or the end of the scan shows
// whether it is the last beat.
// A probe without any match returns one no-match beat with last set.
// req is taken only between probes and while the output register can accept.
// When rsp stalls, the scan freezes on the next match until the output
// register frees up; no beat is lost.
// Reset empties the table and zeroes the match count at once; table contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module nested_loop_equi_join import nlej_pkg::*; #(
	parameter int TABLE_DEPTH = NLEJ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	nlej_req_if.sink   req,
	nlej_rsp_if.source rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic [ID_W+VAL_W-1:0] table_mem [TABLE_DEPTH];

	logic          state_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] idx_q;
	cnt_t          count_q;
	logic          pend_valid_q;
	logic          out_valid_q;

	id_t  probe_id_q;
	val_t probe_key_q;
	id_t  pend_rid_q;
	cnt_t pend_total_q;

	logic rd_valid_s1;
	val_t rd_key_s1;
	id_t  rd_id_s1;

	logic [STAT_W-1:0] out_status_q;
	id_t               out_left_q;
	id_t               out_right_q;
	val_t              out_val_q;
	cnt_t              out_total_q;
	logic              out_last_q;

	logic out_free, req_fire, full, scan_issue, hit, stall, advance, scan_end;
	cnt_t count_inc;

	logic              out_load;
	logic [STAT_W-1:0] out_status_d;
	id_t               out_left_d;
	id_t               out_right_d;
	val_t              out_val_d;
	cnt_t              out_total_d;
	logic              out_last_d;

	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == ST_IDLE) && out_free;
	assign req_fire   = req.valid && req.ready;
	assign full       = fill_q >= FW'(TABLE_DEPTH);
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < fill_q);
	assign hit        = rd_valid_s1 && (rd_key_s1 == probe_key_q);
	assign stall      = hit && pend_valid_q && !out_free;
	assign advance    = (state_q == ST_SCAN) && !stall;
	assign scan_end   = (state_q == ST_SCAN) && !scan_issue && !rd_valid_s1 && out_free;
	assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;

	always_comb begin
		out_load     = 1'b0;
		out_status_d = STAT_MATCH;
		out_left_d   = probe_id_q;
		out_right_d  = pend_rid_q;
		out_val_d    = probe_key_q;
		out_total_d  = pend_total_q;
		out_last_d   = 1'b0;
		if (req_fire && req.cmd == CMD_LOAD && full) begin
			out_load     = 1'b1;
			out_status_d = STAT_FULL;
			out_left_d   = '0;
			out_right_d  = req.tuple_id;
			out_val_d    = req.tuple_val;
			out_total_d  = count_q;
			out_last_d   = 1'b1;
		end else if (advance && hit && pend_valid_q) begin
			out_load = 1'b1;
		end else if (scan_end) begin
			out_load   = 1'b1;
			out_last_d = 1'b1;
			if (!pend_valid_q) begin
				out_status_d = STAT_NOMATCH;
				out_right_d  = '0;
				out_total_d  = count_q;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (req_fire) begin
				case (req.cmd)
					CMD_CLEAR: begin
						fill_q  <= '0;
						count_q <= '0;
					end
					CMD_LOAD: begin
						if (!full) fill_q <= fill_q + 1'b1;
					end
					CMD_PROBE: begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						pend_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (advance) begin
				rd_valid_s1 <= scan_issue;
				if (scan_issue) idx_q <= idx_q + 1'b1;
				if (hit) begin
					count_q      <= count_inc;
					pend_valid_q <= 1'b1;
				end
			end
			if (scan_end) begin
				state_q      <= ST_IDLE;
				pend_valid_q <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (req_fire && req.cmd == CMD_LOAD && !full) begin
			table_mem[fill_q[AW-1:0]] <= {req.tuple_val, req.tuple_id};
		end
		if (advance && scan_issue) begin
			{rd_key_s1, rd_id_s1} <= table_mem[idx_q[AW-1:0]];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_fire && req.cmd == CMD_PROBE) begin
			probe_id_q  <= req.tuple_id;
			probe_key_q <= req.tuple_val;
		end
		if (advance && hit) begin
			pend_rid_q   <= rd_id_s1;
			pend_total_q <= count_inc;
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_left_q   <= out_left_d;
			out_right_q  <= out_right_d;
			out_val_q    <= out_val_d;
			out_total_q  <= out_total_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.left_id     = out_left_q;
	assign rsp.right_id    = out_right_q;
	assign rsp.match_val   = out_val_q;
	assign rsp.match_total = out_total_q;
	assign rsp.last        = out_last_q;

endmodule

// ===== tb/nested_loop_equi_join_test.sv =====
// ----------------------------------------------------------------------------
// nested_loop_equi_join_test
// Self-checking bench for the equi-join engine. A directed table covers the
// empty table, key and id extremes, duplicate keys, the unused command and
// clear; random phases then load tables of varied fill (overfilling some),
// probe them from a small key pool and check every result beat, in order,
// against an in-bench join predictor. Both channels idle at random and the
// result side holds off once for a long stretch to back up the engine.
// ----------------------------------------------------------------------------
module nested_loop_equi_join_test;
	import nlej_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam val_t KEY_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
	localparam val_t KEY_MAX     = {1'b0, {(VAL_W-1){1'b1}}};
	localparam id_t  ID_MAX      = '1;
	localparam int   RAND_ITEMS  = 480;
	localparam int   LONG_HOLD   = 400;
	localparam int   STALL_LIMIT = 4000;
	localparam int   DRAIN_WAIT  = 100;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		id_t               left_id;
		id_t               right_id;
		val_t              match_val;
		cnt_t              match_total;
		logic              last;
	} join_beat_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		id_t              id;
		val_t             val;
		logic             typed;
		join_beat_t       beat;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nlej_req_if req_ch ();
	nlej_rsp_if rsp_ch ();

	nested_loop_equi_join u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	val_t       tbl_key [NLEJ_DEPTH];
	id_t        tbl_id [NLEJ_DEPTH];
	int         tbl_fill = 0;
	cnt_t       match_cnt = '0;
	join_beat_t exp_join_beats[$];
	int         err_count = 0;
	int         beats_seen = 0;
	int         items_done = 0;
	int         stall_cycles;

	function automatic join_beat_t mk_beat(logic [STAT_W-1:0] status, id_t lid, id_t rid,
		val_t mval, cnt_t total, logic last);
		join_beat_t b;
		b.status      = status;
		b.left_id     = lid;
		b.right_id    = rid;
		b.match_val   = mval;
		b.match_total = total;
		b.last        = last;
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic val_t pick_key();
		case ($urandom_range(0, 7))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			3: return '1;
			default: return val_t'($urandom());
		endcase
	endfunction

	function automatic stim_row_t dir_plain(logic [CMD_W-1:0] cmd, id_t id, val_t val);
		stim_row_t s;
		s.cmd   = cmd;
		s.id    = id;
		s.val   = val;
		s.typed = 1'b0;
		s.beat  = '0;
		return s;
	endfunction

	function automatic stim_row_t dir_typed(logic [CMD_W-1:0] cmd, id_t id, val_t val,
		join_beat_t beat);
		stim_row_t s;
		s = dir_plain(cmd, id, val);
		s.typed = 1'b1;
		s.beat  = beat;
		return s;
	endfunction

	task automatic join_predict(input logic [CMD_W-1:0] cmd, input id_t id, input val_t val);
		int hits;
		join_beat_t b;
		hits = 0;
		case (cmd)
			CMD_CLEAR: begin
				tbl_fill  = 0;
				match_cnt = '0;
			end
			CMD_LOAD: begin
				if (tbl_fill >= NLEJ_DEPTH) begin
					exp_join_beats.push_back(mk_beat(STAT_FULL, '0, id, val, match_cnt, 1'b1));
				end else begin
					tbl_key[tbl_fill] = val;
					tbl_id[tbl_fill]  = id;
					tbl_fill++;
				end
			end
			CMD_PROBE: begin
				for (int j = 0; j < tbl_fill; j++) begin
					if (tbl_key[j] == val) begin
						if (match_cnt != '1) match_cnt++;
						exp_join_beats.push_back(mk_beat(STAT_MATCH, id, tbl_id[j], val,
							match_cnt, 1'b0));
						hits++;
					end
				end
				if (hits == 0) begin
					exp_join_beats.push_back(mk_beat(STAT_NOMATCH, id, '0, val, match_cnt, 1'b1));
				end else begin
					b = exp_join_beats.pop_back();
					b.last = 1'b1;
					exp_join_beats.push_back(b);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input id_t id, input val_t val,
		input bit quiet, input logic typed, input join_beat_t beat);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= cmd;
		req_ch.tuple_id  <= id;
		req_ch.tuple_val <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		join_predict(cmd, id, val);
		if (typed) begin
			void'(exp_join_beats.pop_back());
			exp_join_beats.push_back(beat);
		end
		if (cmd != CMD_UNUSED) items_done++;
	endtask

	// result side pacing, with one long hold-off to back up the engine
	initial begin : rsp_pace
		int gap;
		bit held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			gap = pick_gap();
			if (!held && beats_seen >= 40) begin
				held = 1'b1;
				gap  = LONG_HOLD;
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		join_beat_t want;
		join_beat_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			beats_seen <= beats_seen + 1;
			got = mk_beat(rsp_ch.status, rsp_ch.left_id, rsp_ch.right_id, rsp_ch.match_val,
				rsp_ch.match_total, rsp_ch.last);
			if (exp_join_beats.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: unexpected beat st=%0d lid=%h rid=%h val=%h tot=%h last=%0d",
						$time, got.status, got.left_id, got.right_id, got.match_val,
						got.match_total, got.last);
			end else begin
				want = exp_join_beats.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= 10) begin
						$display("%0t: beat mismatch", $time);
						$display("  exp st=%0d lid=%h rid=%h val=%h tot=%h last=%0d",
							want.status, want.left_id, want.right_id, want.match_val,
							want.match_total, want.last);
						$display("  got st=%0d lid=%h rid=%h val=%h tot=%h last=%0d",
							got.status, got.left_id, got.right_id, got.match_val,
							got.match_total, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** nested_loop_equi_join: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stim
		stim_row_t dir_rows[$];
		val_t keys [3];
		int n_load;
		int n_probe;
		int r;
		bit quiet;
		bit first_phase;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_CLEAR;
		req_ch.tuple_id  = '0;
		req_ch.tuple_val = '0;

		dir_rows.push_back(dir_typed(CMD_PROBE, 31'd5, 32'sd7,
			mk_beat(STAT_NOMATCH, 31'd5, '0, 32'sd7, '0, 1'b1)));
		dir_rows.push_back(dir_plain(CMD_UNUSED, ID_MAX, KEY_MIN));
		dir_rows.push_back(dir_plain(CMD_LOAD, '0, KEY_MIN));
		dir_rows.push_back(dir_plain(CMD_LOAD, ID_MAX, KEY_MAX));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'd1, '0));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'd2, '1));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'd3, KEY_MAX));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'd4, '0));
		dir_rows.push_back(dir_plain(CMD_PROBE, ID_MAX, KEY_MAX));
		dir_rows.push_back(dir_plain(CMD_PROBE, '0, KEY_MIN));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'd9, '0));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'd10, '1));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'd11, 32'sd1));
		dir_rows.push_back(dir_plain(CMD_UNUSED, '0, '0));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'd12, '1));
		dir_rows.push_back(dir_plain(CMD_CLEAR, '0, '0));
		dir_rows.push_back(dir_typed(CMD_PROBE, ID_MAX, KEY_MIN,
			mk_beat(STAT_NOMATCH, ID_MAX, '0, KEY_MIN, '0, 1'b1)));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'h5555_5555, 32'shAAAA_AAAA));
		dir_rows.push_back(dir_plain(CMD_LOAD, 31'h2AAA_AAAA, 32'sh5555_5555));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'h2AAA_AAAA, 32'shAAAA_AAAA));
		dir_rows.push_back(dir_plain(CMD_PROBE, 31'h5555_5555, 32'sh5555_5555));
		dir_rows.push_back(dir_plain(CMD_CLEAR, ID_MAX, '1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].val, 1'b0,
				dir_rows[i].typed, dir_rows[i].beat);

		items_done  = 0;
		first_phase = 1'b1;
		while (items_done < RAND_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (first_phase || $urandom_range(0, 99) < 85)
				send_cmd(CMD_CLEAR, id_t'($urandom()), val_t'($urandom()), quiet, 1'b0, '0);
			r = $urandom_range(0, 99);
			if (first_phase || r < 8) n_load = $urandom_range(60, 70);
			else if (r < 20) n_load = $urandom_range(9, 24);
			else n_load = $urandom_range(0, 8);
			foreach (keys[k]) keys[k] = pick_key();
			for (int k = 0; k < n_load; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_cmd(CMD_UNUSED, id_t'($urandom()), val_t'($urandom()), quiet, 1'b0, '0);
				if ($urandom_range(0, 9) == 0)
					send_cmd(CMD_PROBE, id_t'($urandom()), keys[$urandom_range(0, 2)], quiet,
						1'b0, '0);
				send_cmd(CMD_LOAD, id_t'($urandom()),
					($urandom_range(0, 4) == 0) ? pick_key() : keys[$urandom_range(0, 2)],
					quiet, 1'b0, '0);
			end
			n_probe = $urandom_range(1, 6);
			for (int k = 0; k < n_probe; k++)
				send_cmd(CMD_PROBE, id_t'($urandom()),
					($urandom_range(0, 3) == 0) ? pick_key() : keys[$urandom_range(0, 2)],
					quiet, 1'b0, '0);
			first_phase = 1'b0;
		end
		req_ch.valid <= 1'b0;

		while (exp_join_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_count == 0 && exp_join_beats.size() == 0) begin
			$display("** nested_loop_equi_join: PASSED **");
		end else begin
			$display("** nested_loop_equi_join: FAILED **");
		end
		$finish;
	end

endmodule
